@@ hdl/rfae_pkg.sv @@
// Shared types and constants for the register-file ALU executor.
package rfae_pkg;

   localparam int unsigned OP_W    = 4;
   localparam int unsigned REG_W   = 5;
   localparam int unsigned WORD_W  = 32;
   localparam int unsigned IDX_SPAN = 32;

   localparam logic [OP_W-1:0] OP_ADD  = 4'd0;
   localparam logic [OP_W-1:0] OP_SUB  = 4'd1;
   localparam logic [OP_W-1:0] OP_SLT  = 4'd2;
   localparam logic [OP_W-1:0] OP_AND  = 4'd3;
   localparam logic [OP_W-1:0] OP_OR   = 4'd4;
   localparam logic [OP_W-1:0] OP_NOR  = 4'd5;
   localparam logic [OP_W-1:0] OP_XOR  = 4'd6;
   localparam logic [OP_W-1:0] OP_LI   = 4'd7;
   localparam logic [OP_W-1:0] OP_ADDI = 4'd8;
   localparam logic [OP_W-1:0] OP_SLTI = 4'd9;
   localparam logic [OP_W-1:0] OP_ANDI = 4'd10;
   localparam logic [OP_W-1:0] OP_ORI  = 4'd11;
   localparam logic [OP_W-1:0] OP_XORI = 4'd12;

   localparam logic [WORD_W-1:0] PC_STEP = 32'd4;

   typedef struct packed {
      logic [OP_W-1:0]          req_type;
      logic [REG_W-1:0]         dest_reg;
      logic [REG_W-1:0]         src_a_reg;
      logic [REG_W-1:0]         src_b_reg;
      logic signed [WORD_W-1:0] immediate;
   } req_item_type;

   typedef struct packed {
      logic [REG_W-1:0]         write_reg;
      logic signed [WORD_W-1:0] write_value;
      logic [WORD_W-1:0]        pc_after;
   } rsp_item_type;

endpackage

@@ hdl/rfae_regfile.sv @@
// Register file memory with registered read, reset-value valid bits and write bypass.
module rfae_regfile import rfae_pkg::*; #(
   parameter int NUM_REGS   = 32,
   parameter int DATA_WIDTH = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        rd_en,
   input  logic [$clog2(NUM_REGS)-1:0] rd_addr_a,
   input  logic [$clog2(NUM_REGS)-1:0] rd_addr_b,
   input  logic                        wr_en,
   input  logic [$clog2(NUM_REGS)-1:0] wr_addr,
   input  logic [DATA_WIDTH-1:0]       wr_data,
   output logic [DATA_WIDTH-1:0]       rd_data_a,
   output logic [DATA_WIDTH-1:0]       rd_data_b
);

   localparam int IDX_W = $clog2(NUM_REGS);

   logic [DATA_WIDTH-1:0] mem [NUM_REGS];
   logic [DATA_WIDTH-1:0] raw_a_ff, raw_b_ff;
   logic [NUM_REGS-1:0]   valid_ff;
   logic                  vld_a_ff, vld_b_ff;
   logic [IDX_W-1:0]      addr_a_ff, addr_b_ff;
   logic                  byp_en_ff;
   logic [IDX_W-1:0]      byp_addr_ff;
   logic [DATA_WIDTH-1:0] byp_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         raw_a_ff <= mem[rd_addr_a];
         raw_b_ff <= mem[rd_addr_b];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         byp_en_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         // capture the write that lands on the same edge as the read
         if (rd_en) begin
            byp_en_ff <= wr_en;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         vld_a_ff    <= valid_ff[rd_addr_a];
         vld_b_ff    <= valid_ff[rd_addr_b];
         addr_a_ff   <= rd_addr_a;
         addr_b_ff   <= rd_addr_b;
         byp_addr_ff <= wr_addr;
         byp_data_ff <= wr_data;
      end
   end

   always_comb begin
      if (byp_en_ff && (byp_addr_ff == addr_a_ff)) begin
         rd_data_a = byp_data_ff;
      end else if (vld_a_ff) begin
         rd_data_a = raw_a_ff;
      end else begin
         rd_data_a = DATA_WIDTH'(addr_a_ff) + DATA_WIDTH'(1);
      end
      if (byp_en_ff && (byp_addr_ff == addr_b_ff)) begin
         rd_data_b = byp_data_ff;
      end else if (vld_b_ff) begin
         rd_data_b = raw_b_ff;
      end else begin
         rd_data_b = DATA_WIDTH'(addr_b_ff) + DATA_WIDTH'(1);
      end
   end

endmodule

@@ hdl/rfae_alu.sv @@
// Integer ALU: operand select, operation decode and write enable.
module rfae_alu import rfae_pkg::*; #(
   parameter int DATA_WIDTH = 32
) (
   input  logic [OP_W-1:0]       op,
   input  logic [DATA_WIDTH-1:0] opnd_a,
   input  logic [DATA_WIDTH-1:0] opnd_b,
   input  logic [DATA_WIDTH-1:0] imm,
   output logic [DATA_WIDTH-1:0] result,
   output logic                  wr_en
);

   logic [DATA_WIDTH-1:0] src_b;
   logic                  less;

   always_comb begin
      case (op) inside
         OP_ADDI, OP_SLTI, OP_ANDI, OP_ORI, OP_XORI: src_b = imm;
         default:                                    src_b = opnd_b;
      endcase
      less  = $signed(opnd_a) < $signed(src_b);
      wr_en = 1'b1;
      case (op) inside
         OP_ADD, OP_ADDI: result = opnd_a + src_b;
         OP_SUB:          result = opnd_a - src_b;
         OP_SLT, OP_SLTI: result = {{(DATA_WIDTH-1){1'b0}}, less};
         OP_AND, OP_ANDI: result = opnd_a & src_b;
         OP_OR, OP_ORI:   result = opnd_a | src_b;
         OP_NOR:          result = ~(opnd_a | src_b);
         OP_XOR, OP_XORI: result = opnd_a ^ src_b;
         OP_LI:           result = imm;
         default: begin
            // unused code: report destination content, write nothing
            result = opnd_b;
            wr_en  = 1'b0;
         end
      endcase
   end

endmodule

@@ hdl/register_file_alu_executor.sv @@
// Top level of the register-file ALU executor.
//
// Executes one ALU instruction per item against a register file of NUM_REGS
// words of DATA_WIDTH bits, and returns one result item per request: the
// written register index, its new value (low 32 bits) and the program counter
// after the step. The block sustains one item per cycle while rsp_ready is
// held. The register-file memory is read on the accepting edge into the
// execute stage; the ALU result is captured in the output register when that
// register is empty or being emptied, and is then presented as rsp_item. A write
// of the previous item is forwarded to operands read on the same edge, so
// dependent instructions issue back to back. Register indices are reduced
// modulo NUM_REGS; after reset register i reads i+1 through per-entry valid
// bits, so no clearing pass is needed and requests are taken right after
// reset. Unused operation codes write nothing and report the destination's
// current content. Ready depends combinationally on rsp_ready.
module register_file_alu_executor import rfae_pkg::*; #(
   parameter int NUM_REGS   = 32,
   parameter int DATA_WIDTH = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_item_type req_item,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_item_type rsp_item
);

   localparam int IDX_W = $clog2(NUM_REGS);

   // index reduction table: raw 5-bit index to register address
   logic [IDX_W-1:0] mod_lut [IDX_SPAN];
   for (genvar i = 0; i < IDX_SPAN; i++) begin : g_mod
      assign mod_lut[i] = IDX_W'(i % NUM_REGS);
   end

   logic                  req_fire;
   logic                  s1_move;
   logic                  op_unused;
   logic [IDX_W-1:0]      rd_addr_a, rd_addr_b;
   logic [63:0]           imm_wide;

   // execute stage
   logic                  s1_valid_ff, s1_valid_in;
   logic [OP_W-1:0]       s1_op_ff;
   logic [IDX_W-1:0]      s1_rd_ff;
   logic [DATA_WIDTH-1:0] s1_imm_ff;

   logic [DATA_WIDTH-1:0] opnd_a, opnd_b;
   logic [DATA_WIDTH-1:0] alu_result;
   logic                  alu_wr_en;
   logic [63:0]           result_wide;
   logic [7:0]            rd_wide;

   // output register
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_item_type          rsp_item_ff;
   logic [WORD_W-1:0]     pc_ff;

   assign req_fire  = req_valid && req_ready;
   assign s1_move   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || s1_move;

   // unused codes read the destination on port b to report its content
   assign op_unused = req_item.req_type > OP_XORI;
   assign rd_addr_a = mod_lut[req_item.src_a_reg];
   assign rd_addr_b = op_unused ? mod_lut[req_item.dest_reg] : mod_lut[req_item.src_b_reg];
   assign imm_wide  = 64'(req_item.immediate);

   rfae_regfile #(
      .NUM_REGS   (NUM_REGS),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_regfile (
      .clock     (clock),
      .reset     (reset),
      .rd_en     (req_fire),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .wr_en     (s1_move && alu_wr_en),
      .wr_addr   (s1_rd_ff),
      .wr_data   (alu_result),
      .rd_data_a (opnd_a),
      .rd_data_b (opnd_b)
   );

   rfae_alu #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_alu (
      .op     (s1_op_ff),
      .opnd_a (opnd_a),
      .opnd_b (opnd_b),
      .imm    (s1_imm_ff),
      .result (alu_result),
      .wr_en  (alu_wr_en)
   );

   assign result_wide = 64'(alu_result);
   assign rd_wide     = 8'(s1_rd_ff);

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_fire) begin
         s1_valid_in = 1'b1;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (s1_move) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pc_ff        <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (s1_move) begin
            pc_ff <= pc_ff + PC_STEP;
         end
      end
   end

   // hold decoded fields while the item waits in the execute stage
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_op_ff  <= req_item.req_type;
         s1_rd_ff  <= mod_lut[req_item.dest_reg];
         s1_imm_ff <= imm_wide[DATA_WIDTH-1:0];
      end
      if (s1_move) begin
         rsp_item_ff.write_reg   <= rd_wide[REG_W-1:0];
         rsp_item_ff.write_value <= result_wide[WORD_W-1:0];
         rsp_item_ff.pc_after    <= pc_ff + PC_STEP;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

@@ hdl/rfae_checker.sv @@
// Port-level checker for the register-file ALU executor, with its bind.
module rfae_checker import rfae_pkg::*; #(
   parameter int NUM_REGS = 32
) (
   input logic         clock,
   input logic         reset,
   input logic         req_valid,
   input logic         req_ready,
   input req_item_type req_item,
   input logic         rsp_valid,
   input logic         rsp_ready,
   input rsp_item_type rsp_item
);

   logic [1:0]        pend_ff;
   logic [WORD_W-1:0] pc_seen_ff;
   logic              req_fire, rsp_fire;

   assign req_fire = req_valid && req_ready;
   assign rsp_fire = rsp_valid && rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff    <= '0;
         pc_seen_ff <= '0;
      end else begin
         pend_ff <= pend_ff + 2'(req_fire) - 2'(rsp_fire);
         if (rsp_fire) begin
            pc_seen_ff <= rsp_item.pc_after;
         end
      end
   end

   a_pc_step: assert property (@(posedge clock) disable iff (reset)
      rsp_fire |-> rsp_item.pc_after == pc_seen_ff + PC_STEP)
      else $error("pc_after did not advance by one step");

   a_no_orphan: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pend_ff != 2'd0)
      else $error("result item without an accepted request");

   a_depth: assert property (@(posedge clock) disable iff (reset)
      pend_ff != 2'd3)
      else $error("more items in flight than the pipeline holds");

   a_reg_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> 32'(rsp_item.write_reg) < NUM_REGS)
      else $error("write_reg outside the register file");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_item))
      else $error("stalled result item changed");

endmodule

bind register_file_alu_executor rfae_checker #(.NUM_REGS(NUM_REGS)) u_rfae_checker (.*);

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the register-file ALU executor.
module tb;
   import rfae_pkg::*;

   // Codes 13 to 15 decode to no operation.
   localparam logic [OP_W-1:0] OP_SPARE_LO = OP_XORI + 1'b1;
   localparam logic [OP_W-1:0] OP_SPARE_HI = '1;

   localparam int unsigned CYCLE_LIMIT  = 200000;
   localparam int unsigned REPORT_LIMIT = 10;
   localparam int unsigned TAIL_ITEMS   = 150;

   logic         clock     = 1'b0;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   req_item_type req_item  = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   rsp_item_type rsp_item;

   // Shadow copy of the architectural state.
   logic [WORD_W-1:0] shadow_regs [IDX_SPAN];
   logic [WORD_W-1:0] shadow_pc;

   req_item_type instruction_queue [$];
   rsp_item_type expected_writebacks [$];

   int unsigned sender_gap     = 0;
   int unsigned receiver_stall = 0;
   int unsigned cycle_count    = 0;
   int unsigned items_accepted = 0;
   int unsigned results_seen   = 0;
   int unsigned mismatch_count = 0;
   int unsigned drain_pauses   = 0;
   int unsigned op_hits [16];
   bit          tail_phase     = 1'b0;
   bit          quiet_tail     = 1'b0;

   register_file_alu_executor u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Execute one instruction on the shadow state and return its writeback.
   // Operands are read before the destination is updated.
   function automatic rsp_item_type execute_instruction(req_item_type instr);
      logic [WORD_W-1:0] opnd_a;
      logic [WORD_W-1:0] opnd_b;
      logic [WORD_W-1:0] imm;
      logic [WORD_W-1:0] outcome;
      bit                writes;
      rsp_item_type      wb;
      opnd_a  = shadow_regs[instr.src_a_reg];
      opnd_b  = shadow_regs[instr.src_b_reg];
      imm     = instr.immediate;
      outcome = '0;
      writes  = 1'b1;
      case (instr.req_type)
         OP_ADD:  outcome = opnd_a + opnd_b;
         OP_SUB:  outcome = opnd_a - opnd_b;
         OP_SLT:  outcome = ($signed(opnd_a) < $signed(opnd_b)) ? 32'd1 : 32'd0;
         OP_AND:  outcome = opnd_a & opnd_b;
         OP_OR:   outcome = opnd_a | opnd_b;
         OP_NOR:  outcome = ~(opnd_a | opnd_b);
         OP_XOR:  outcome = opnd_a ^ opnd_b;
         OP_LI:   outcome = imm;
         OP_ADDI: outcome = opnd_a + imm;
         OP_SLTI: outcome = ($signed(opnd_a) < $signed(imm)) ? 32'd1 : 32'd0;
         OP_ANDI: outcome = opnd_a & imm;
         OP_ORI:  outcome = opnd_a | imm;
         OP_XORI: outcome = opnd_a ^ imm;
         default: writes = 1'b0;
      endcase
      if (writes)
         shadow_regs[instr.dest_reg] = outcome;
      shadow_pc      = shadow_pc + PC_STEP;
      wb.write_reg   = instr.dest_reg;
      wb.write_value = shadow_regs[instr.dest_reg];
      wb.pc_after    = shadow_pc;
      return wb;
   endfunction

   function automatic req_item_type make_instr(logic [OP_W-1:0] op, int unsigned rd,
                                               int unsigned ra, int unsigned rb,
                                               logic [WORD_W-1:0] imm);
      req_item_type instr;
      instr.req_type  = op;
      instr.dest_reg  = rd[REG_W-1:0];
      instr.src_a_reg = ra[REG_W-1:0];
      instr.src_b_reg = rb[REG_W-1:0];
      instr.immediate = imm;
      return instr;
   endfunction

   // Append one item to the tail of the pending queue.
   task automatic enqueue_instr(req_item_type instr);
      instruction_queue = {instruction_queue, instr};
   endtask

   // Compare one accepted result item against the oldest expected writeback.
   task automatic check_writeback(rsp_item_type got);
      rsp_item_type want;
      if (expected_writebacks.size() == 0) begin
         mismatch_count++;
         if (mismatch_count <= REPORT_LIMIT)
            $display("ERROR: unexpected result item reg %0d value %h pc %h",
                     got.write_reg, got.write_value, got.pc_after);
      end else begin
         want = expected_writebacks.pop_front();
         if (got.write_reg !== want.write_reg || got.write_value !== want.write_value ||
             got.pc_after !== want.pc_after) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT) begin
               $display("ERROR: result %0d expected reg %0d value %h pc %h",
                        results_seen, want.write_reg, want.write_value, want.pc_after);
               $display("       got reg %0d value %h pc %h",
                        got.write_reg, got.write_value, got.pc_after);
            end
         end
      end
      results_seen++;
   endtask

   // Random operand value: corners often, anything else otherwise.
   function automatic logic [WORD_W-1:0] pick_word();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return 32'd1;
         2: return '1;
         3: return 32'h8000_0000;
         4: return 32'h7fff_ffff;
         default: return $urandom;
      endcase
   endfunction

   // Random instructions; each source reuses the last destination about a third
   // of the time, so that back-to-back dependencies hit the forwarding path.
   task automatic queue_random(int unsigned count);
      logic [OP_W-1:0] op;
      int unsigned     rd;
      int unsigned     ra;
      int unsigned     rb;
      int unsigned     last_rd;
      last_rd = 0;
      repeat (count) begin
         if ($urandom_range(0, 9) == 0)
            op = OP_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
         else
            op = OP_W'($urandom_range(OP_ADD, OP_XORI));
         rd = $urandom_range(0, IDX_SPAN - 1);
         ra = ($urandom_range(0, 2) == 0) ? last_rd : $urandom_range(0, IDX_SPAN - 1);
         rb = ($urandom_range(0, 2) == 0) ? last_rd : $urandom_range(0, IDX_SPAN - 1);
         enqueue_instr(make_instr(op, rd, ra, rb, pick_word()));
         last_rd = rd;
      end
   endtask

   // Hold off until every queued item is taken and every writeback is back.
   task automatic wait_drained();
      do
         @(negedge clock);
      while (instruction_queue.size() != 0 || req_valid || expected_writebacks.size() != 0);
   endtask

   // Decide idling for both sides from settled values, so neither side races the other.
   always @(negedge clock) begin
      quiet_tail <= tail_phase && (instruction_queue.size() < TAIL_ITEMS);
   end

   // Driver: predict on acceptance, then present the next item or idle for a burst.
   always @(posedge clock) begin
      if (reset) begin
         req_valid  <= 1'b0;
         sender_gap <= 0;
      end else begin
         if (req_valid && req_ready) begin
            expected_writebacks = {expected_writebacks, execute_instruction(req_item)};
            op_hits[req_item.req_type]++;
            items_accepted++;
         end
         if (!req_valid || req_ready) begin
            if (sender_gap != 0) begin
               sender_gap <= sender_gap - 1;
               req_valid  <= 1'b0;
            end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
               // start an idle burst of random length
               sender_gap <= $urandom_range(0, 9);
               req_valid  <= 1'b0;
            end else if (instruction_queue.size() != 0) begin
               req_item  <= instruction_queue.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: check each accepted result item, and stall the result side in bursts.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready      <= 1'b0;
         receiver_stall <= 0;
      end else begin
         if (rsp_valid && rsp_ready)
            check_writeback(rsp_item);
         if (receiver_stall != 0) begin
            receiver_stall <= receiver_stall - 1;
            rsp_ready      <= 1'b0;
         end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
            receiver_stall <= $urandom_range(0, 9);
            rsp_ready      <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Watchdog against a hung handshake.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("ERROR: timeout after %0d cycles, %0d results outstanding",
                  cycle_count, expected_writebacks.size());
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   initial begin
      int unsigned ops_covered;
      // Reset state of the shadow: register i holds i+1, pc at zero.
      for (int i = 0; i < IDX_SPAN; i++)
         shadow_regs[i] = i + 1;
      shadow_pc = '0;
      foreach (op_hits[i])
         op_hits[i] = 0;

      // Directed part: corners of every operation.
      enqueue_instr(make_instr(OP_LI,   1,  0,  0, 32'h7fff_ffff));
      enqueue_instr(make_instr(OP_LI,   2, 31, 31, 32'h8000_0000));
      enqueue_instr(make_instr(OP_ADD,  3,  1,  1, 32'hffff_ffff)); // signed overflow
      enqueue_instr(make_instr(OP_SUB,  4,  2,  1, '0));
      enqueue_instr(make_instr(OP_SUB,  5,  0, 31, '0));            // borrow through zero
      enqueue_instr(make_instr(OP_SLT,  6,  2,  1, '0));            // min < max
      enqueue_instr(make_instr(OP_SLT,  7,  1,  2, '0));            // max < min
      enqueue_instr(make_instr(OP_AND,  8,  1,  2, '0));
      enqueue_instr(make_instr(OP_OR,   9,  1,  2, '0));
      enqueue_instr(make_instr(OP_NOR,  0,  0, 31, '0));            // register 0 written
      enqueue_instr(make_instr(OP_XOR, 31, 31,  1, '0));
      enqueue_instr(make_instr(OP_ADDI, 10, 1, 31, 32'd1));         // wraps to min
      enqueue_instr(make_instr(OP_ADDI, 11, 2,  0, 32'hffff_ffff));
      enqueue_instr(make_instr(OP_SLTI, 12, 2,  0, 32'hffff_ffff));
      enqueue_instr(make_instr(OP_SLTI, 13, 1,  0, 32'h8000_0000));
      enqueue_instr(make_instr(OP_ANDI, 14, 0, 31, 32'hffff_ffff));
      enqueue_instr(make_instr(OP_ORI,  15, 15, 0, 32'h8000_0000)); // rd is the source
      enqueue_instr(make_instr(OP_XORI, 16, 16, 0, 32'hffff_ffff));
      enqueue_instr(make_instr(OP_ADD,  17, 17, 17, '0));
      enqueue_instr(make_instr(OP_ADD,  18, 17, 3, 32'h1234_5678)); // uses prior rd
      enqueue_instr(make_instr(OP_SPARE_LO,        20, 1, 2, '1));  // no write
      enqueue_instr(make_instr(OP_SPARE_LO + 1'b1,  0, 0, 0, '0));
      enqueue_instr(make_instr(OP_SPARE_HI,        31, 31, 31, '1));
      enqueue_instr(make_instr(OP_LI,  21, 31, 31, '0));

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Phases separated by full drains of the pipeline.
      wait_drained();
      drain_pauses++;
      queue_random(400);
      wait_drained();
      drain_pauses++;
      tail_phase = 1'b1;
      queue_random(426);
      wait_drained();
      repeat (8) @(posedge clock);

      ops_covered = 0;
      foreach (op_hits[i])
         if (op_hits[i] != 0)
            ops_covered++;
      $display("Executed %0d instructions covering %0d of 16 opcodes, %0d writebacks checked",
               items_accepted, ops_covered, results_seen);
      $display("Pipeline drained %0d times mid-run, final pc %h", drain_pauses, shadow_pc);
      if (mismatch_count == 0 && expected_writebacks.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("%0d mismatches, %0d writebacks missing", mismatch_count,
                  expected_writebacks.size());
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
